/* rtl/core/mrfp_pkg.sv */
// ----------------------------------------------------------------------------
// mrfp_pkg: shared types and constants of the radio frame parser
// Frame geometry, protobuf wire codes, result codes and the transfer structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfp_pkg;

	// frame geometry
	localparam int unsigned MaxFrameBytes = 255;
	localparam int unsigned HdrBytes      = 16;
	localparam int unsigned OffsetW       = $clog2(MaxFrameBytes + 1);
	localparam int unsigned LenW          = $clog2(MaxFrameBytes + 1);

	// varint limits: count holds 0 .. VarintMaxBytes-1
	localparam int unsigned VarintMaxBytes = 10;
	localparam int unsigned VarintCntW     = $clog2(VarintMaxBytes);

	// result queue
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	// protobuf wire types
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LEN     = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	// fixed field lengths
	localparam logic [LenW-1:0] LEN_FIXED64 = LenW'(8);
	localparam logic [LenW-1:0] LEN_FIXED32 = LenW'(4);

	// result kinds
	localparam logic [1:0] KIND_BODY    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// summary status
	localparam logic [1:0] STAT_DECODED     = 2'd0;
	localparam logic [1:0] STAT_UNDECODABLE = 2'd1;
	localparam logic [1:0] STAT_SHORT       = 2'd2;

	// body parser phase
	typedef enum logic [1:0] {
		PH_TAG,
		PH_VALUE,
		PH_LENGTH,
		PH_BYTES
	} phase_t;

	// class of the field being parsed
	typedef enum logic [1:0] {
		CLS_OTHER,
		CLS_PORT,
		CLS_PAYLOAD
	} field_cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  body_byte;
		logic [31:0] destination;
		logic [31:0] source_node;
		logic [31:0] packet_id;
		logic [2:0]  hop_limit;
		logic        want_ack;
		logic        via_mqtt;
		logic [2:0]  hop_start;
		logic [7:0]  channel_hash;
		logic [31:0] port_number;
		logic [1:0]  status;
	} out_item_t;

	// decoder view after the current body byte
	typedef struct packed {
		logic        payload;
		logic        ok;
		logic [31:0] port;
	} dec_status_t;

endpackage

`default_nettype wire

/* rtl/core/mrfp_wire_decoder.sv */
// ----------------------------------------------------------------------------
// mrfp_wire_decoder: protobuf body decoder
// Walks tags, varints and length-delimited fields one body byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_wire_decoder (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 clear,
	input  wire logic [7:0]           data_byte,
	output mrfp_pkg::dec_status_t     dec
);

	mrfp_pkg::phase_t                      phase_q, phase_nx;
	mrfp_pkg::field_cls_t                  cls_q, cls_nx;
	logic [31:0]                           low_q, low_nx, low_feed;
	logic                                  hi_q, hi_nx, hi_feed;
	logic [mrfp_pkg::VarintCntW-1:0]       cnt_q, cnt_nx;
	logic [mrfp_pkg::LenW-1:0]             left_q, left_nx;
	logic [31:0]                           port_q, port_nx;
	logic                                  failed_q, failed_nx;
	logic [2:0]                            wire_type;
	logic                                  is_field1, is_field2;

	// merge this byte into the varint: low 32 bits kept, upper bits as a sticky flag
	always_comb begin
		low_feed = low_q;
		hi_feed  = hi_q;
		unique case (cnt_q)
			4'd0: low_feed = low_q | {25'd0, data_byte[6:0]};
			4'd1: low_feed = low_q | {18'd0, data_byte[6:0], 7'd0};
			4'd2: low_feed = low_q | {11'd0, data_byte[6:0], 14'd0};
			4'd3: low_feed = low_q | {4'd0, data_byte[6:0], 21'd0};
			4'd4: begin
				low_feed = low_q | {data_byte[3:0], 28'd0};
				hi_feed  = hi_q | (|data_byte[6:4]);
			end
			4'd9: hi_feed = hi_q | data_byte[0];
			default: hi_feed = hi_q | (|data_byte[6:0]);
		endcase
	end

	// tag decode on the completed varint
	assign wire_type = low_feed[2:0];
	assign is_field1 = !hi_feed && (low_feed[31:3] == 29'd1);
	assign is_field2 = !hi_feed && (low_feed[31:3] == 29'd2);

	// next state
	always_comb begin
		phase_nx  = phase_q;
		cls_nx    = cls_q;
		low_nx    = low_q;
		hi_nx     = hi_q;
		cnt_nx    = cnt_q;
		left_nx   = left_q;
		port_nx   = port_q;
		failed_nx = failed_q;
		if (step && !failed_q) begin
			if (phase_q == mrfp_pkg::PH_BYTES) begin
				left_nx = left_q - 1'b1;
				if (left_q == mrfp_pkg::LenW'(1)) begin
					phase_nx = mrfp_pkg::PH_TAG;
				end
			end else if (data_byte[7]) begin
				// continuation byte
				if (cnt_q == mrfp_pkg::VarintCntW'(mrfp_pkg::VarintMaxBytes - 1)) begin
					failed_nx = 1'b1;
				end else begin
					cnt_nx = cnt_q + 1'b1;
					low_nx = low_feed;
					hi_nx  = hi_feed;
				end
			end else begin
				// varint complete: accumulator restarts in every case
				low_nx = '0;
				hi_nx  = 1'b0;
				cnt_nx = '0;
				unique case (phase_q)
					mrfp_pkg::PH_TAG: begin
						if (is_field1 && wire_type == mrfp_pkg::WIRE_VARINT) begin
							cls_nx   = mrfp_pkg::CLS_PORT;
							phase_nx = mrfp_pkg::PH_VALUE;
						end else if (is_field2 && wire_type == mrfp_pkg::WIRE_LEN) begin
							cls_nx   = mrfp_pkg::CLS_PAYLOAD;
							phase_nx = mrfp_pkg::PH_LENGTH;
						end else begin
							cls_nx = mrfp_pkg::CLS_OTHER;
							priority if (wire_type == mrfp_pkg::WIRE_VARINT) begin
								phase_nx = mrfp_pkg::PH_VALUE;
							end else if (wire_type == mrfp_pkg::WIRE_LEN) begin
								phase_nx = mrfp_pkg::PH_LENGTH;
							end else if (wire_type == mrfp_pkg::WIRE_FIXED64) begin
								phase_nx = mrfp_pkg::PH_BYTES;
								left_nx  = mrfp_pkg::LEN_FIXED64;
							end else if (wire_type == mrfp_pkg::WIRE_FIXED32) begin
								phase_nx = mrfp_pkg::PH_BYTES;
								left_nx  = mrfp_pkg::LEN_FIXED32;
							end else begin
								failed_nx = 1'b1;
							end
						end
					end
					mrfp_pkg::PH_VALUE: begin
						if (cls_q == mrfp_pkg::CLS_PORT) begin
							port_nx = low_feed;
						end
						phase_nx = mrfp_pkg::PH_TAG;
					end
					mrfp_pkg::PH_LENGTH: begin
						priority if (hi_feed || low_feed > 32'(mrfp_pkg::MaxFrameBytes)) begin
							failed_nx = 1'b1;
						end else if (low_feed == 32'd0) begin
							phase_nx = mrfp_pkg::PH_TAG;
						end else begin
							phase_nx = mrfp_pkg::PH_BYTES;
							left_nx  = low_feed[mrfp_pkg::LenW-1:0];
						end
					end
					mrfp_pkg::PH_BYTES: begin
						// handled above
					end
				endcase
			end
		end
	end

	// outputs: payload flag for this byte, end-of-frame verdict after it
	always_comb begin
		dec.payload = step && !failed_q && phase_q == mrfp_pkg::PH_BYTES &&
			cls_q == mrfp_pkg::CLS_PAYLOAD;
		dec.ok      = !failed_nx && phase_nx == mrfp_pkg::PH_TAG &&
			cnt_nx == '0 && port_nx != 32'd0;
		dec.port    = port_nx;
	end

	// state registers; clear returns to frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mrfp_pkg::PH_TAG;
			cls_q    <= mrfp_pkg::CLS_OTHER;
			low_q    <= '0;
			hi_q     <= 1'b0;
			cnt_q    <= '0;
			left_q   <= '0;
			port_q   <= '0;
			failed_q <= 1'b0;
		end else if (clear) begin
			phase_q  <= mrfp_pkg::PH_TAG;
			cls_q    <= mrfp_pkg::CLS_OTHER;
			low_q    <= '0;
			hi_q     <= 1'b0;
			cnt_q    <= '0;
			left_q   <= '0;
			port_q   <= '0;
			failed_q <= 1'b0;
		end else begin
			phase_q  <= phase_nx;
			cls_q    <= cls_nx;
			low_q    <= low_nx;
			hi_q     <= hi_nx;
			cnt_q    <= cnt_nx;
			left_q   <= left_nx;
			port_q   <= port_nx;
			failed_q <= failed_nx;
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mrfp_pkg::VarintCntW'(mrfp_pkg::VarintMaxBytes - 1))
		else $error("varint count out of range");
	a_bytes_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mrfp_pkg::PH_BYTES |-> left_q != '0)
		else $error("byte run with nothing left");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (phase_q == mrfp_pkg::PH_TAG && !failed_q && port_q == 32'd0))
		else $error("decoder not back at frame start");

endmodule

`default_nettype wire

/* rtl/core/mrfp_result_queue.sv */
// ----------------------------------------------------------------------------
// mrfp_result_queue: result output queue
// Four-entry queue taking up to two results per cycle when it has room for two, one per transfer out.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfp_result_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [1:0]            push_n,
	input  wire mrfp_pkg::out_item_t   item_a,
	input  wire mrfp_pkg::out_item_t   item_b,
	output logic                       room,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output mrfp_pkg::out_item_t        result
);

	mrfp_pkg::out_item_t               mem_q [mrfp_pkg::QDepth];
	logic [mrfp_pkg::QPtrW-1:0]        wr_q, rd_q, wr_next1;
	logic [mrfp_pkg::QCntW-1:0]        cnt_q;
	logic                              pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = cnt_q != '0;
	assign result       = mem_q[rd_q];
	// room for a full pair, judged on the registered count
	assign room         = cnt_q <= mrfp_pkg::QCntW'(mrfp_pkg::QDepth - 2);
	assign wr_next1     = wr_q + 1'b1;

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= item_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next1] <= item_b;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + mrfp_pkg::QPtrW'(push_n);
			rd_q  <= rd_q + mrfp_pkg::QPtrW'(pop);
			cnt_q <= cnt_q + mrfp_pkg::QCntW'(push_n) - mrfp_pkg::QCntW'(pop);
		end
	end

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("result pushed without room");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mrfp_pkg::QCntW'(mrfp_pkg::QDepth))
		else $error("queue count above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> rd_q == wr_q)
		else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

/* rtl/core/mesh_radio_frame_parser.sv */
// ----------------------------------------------------------------------------
// mesh_radio_frame_parser: radio frame header and body parser
// Unpacks the 16-byte header and decodes the protobuf body byte by byte.
// ----------------------------------------------------------------------------
//  channel   ports                                  carries
//  frame     frame_valid / frame_stall / frame      one frame byte + last mark
//  result    result_valid / result_stall / result   body byte echo or summary
//
//  One byte is taken per cycle while frame_stall is low; bytes land in an
//  input register and are parsed into the result queue on the next edge
//  when it has room for two. A body byte yields one result, a last byte one
//  summary more; header bytes yield none except a summary. Results leave
//  from the queue. Reset clears all parse state; frame_stall rises only
//  when the queue holds more than two results.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_radio_frame_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_valid,
	output logic                      frame_stall,
	input  wire mrfp_pkg::in_item_t   frame,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output mrfp_pkg::out_item_t       result
);

	logic                              valid_s1;
	logic [7:0]                        data_s1;
	logic                              last_s1;
	logic                              room, advance, in_hdr, short_frame, body_step;
	logic [mrfp_pkg::OffsetW-1:0]      off_q;
	logic [31:0]                       dest_q, src_q, id_q;
	logic [7:0]                        flags_q, chan_q;
	mrfp_pkg::dec_status_t             dec;
	mrfp_pkg::out_item_t               body_item, sum_item, item_a, item_b;
	logic [1:0]                        push_n;

	assign frame_stall = valid_s1 && !room;
	assign advance     = valid_s1 && room;
	assign in_hdr      = off_q < mrfp_pkg::OffsetW'(mrfp_pkg::HdrBytes);
	assign short_frame = off_q < mrfp_pkg::OffsetW'(mrfp_pkg::HdrBytes - 1);
	assign body_step   = advance && !in_hdr;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_valid && !frame_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			data_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// header capture and byte offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			dest_q  <= '0;
			src_q   <= '0;
			id_q    <= '0;
			flags_q <= '0;
			chan_q  <= '0;
		end else if (advance) begin
			if (last_s1) begin
				off_q   <= '0;
				dest_q  <= '0;
				src_q   <= '0;
				id_q    <= '0;
				flags_q <= '0;
				chan_q  <= '0;
			end else begin
				if (in_hdr) begin
					unique case (off_q[3:2])
						2'd0: dest_q[{off_q[1:0], 3'b000} +: 8] <= data_s1;
						2'd1: src_q[{off_q[1:0], 3'b000} +: 8]  <= data_s1;
						2'd2: id_q[{off_q[1:0], 3'b000} +: 8]   <= data_s1;
						2'd3: begin
							if (off_q[1:0] == 2'd0) begin
								flags_q <= data_s1;
							end
							if (off_q[1:0] == 2'd1) begin
								chan_q <= data_s1;
							end
						end
					endcase
				end
				// offset saturates on overlong frames
				if (off_q < mrfp_pkg::OffsetW'(mrfp_pkg::MaxFrameBytes)) begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

	mrfp_wire_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (body_step),
		.clear     (advance && last_s1),
		.data_byte (data_s1),
		.dec       (dec)
	);

	// result items
	always_comb begin
		body_item           = '0;
		body_item.item_kind = dec.payload ? mrfp_pkg::KIND_PAYLOAD : mrfp_pkg::KIND_BODY;
		body_item.body_byte = data_s1;

		sum_item           = '0;
		sum_item.item_kind = mrfp_pkg::KIND_SUMMARY;
		if (short_frame) begin
			sum_item.status = mrfp_pkg::STAT_SHORT;
		end else begin
			sum_item.destination  = dest_q;
			sum_item.source_node  = src_q;
			sum_item.packet_id    = id_q;
			sum_item.hop_limit    = flags_q[2:0];
			sum_item.want_ack     = flags_q[3];
			sum_item.via_mqtt     = flags_q[4];
			sum_item.hop_start    = flags_q[7:5];
			sum_item.channel_hash = chan_q;
			sum_item.port_number  = dec.ok ? dec.port : 32'd0;
			sum_item.status       = dec.ok ? mrfp_pkg::STAT_DECODED
				: mrfp_pkg::STAT_UNDECODABLE;
		end
	end

	// queue push: body echo first, summary after it
	always_comb begin
		item_a = body_item;
		item_b = sum_item;
		push_n = 2'd0;
		if (advance) begin
			if (!in_hdr) begin
				push_n = last_s1 ? 2'd2 : 2'd1;
			end else begin
				item_a = sum_item;
				push_n = last_s1 ? 2'd1 : 2'd0;
			end
		end
	end

	mrfp_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_n       (push_n),
		.item_a       (item_a),
		.item_b       (item_b),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// checks
	a_payload_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		dec.payload |-> body_step)
		else $error("payload flag outside a body byte");
	a_pair_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> (last_s1 && body_step))
		else $error("two results without a last body byte");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> off_q == '0)
		else $error("offset not cleared after frame end");

endmodule

`default_nettype wire

/* bench/mesh_radio_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// mesh_radio_frame_parser_tb: self-checking bench for the radio frame parser
// Feeds whole frames byte by byte: directed frames first, then random ones.
// A local model of the header unpacker and the protobuf body decoder predicts
// every echoed body byte and every end-of-frame summary. Both channels idle
// in random bursts. A watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_radio_frame_parser_tb;

	localparam int WdLimit     = 2000;
	localparam int DrainCycles = 32;
	localparam int RandBytes   = 1300;
	localparam int CalmBytes   = 120;

	// one pending frame-side transfer; hold waits for all results first
	typedef struct {
		mrfp_pkg::in_item_t it;
		bit                 hold;
	} frame_tx_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                frame_valid = 1'b0;
	logic                frame_stall;
	mrfp_pkg::in_item_t  frame = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	mrfp_pkg::out_item_t result;

	frame_tx_t           frame_bytes_q[$];
	mrfp_pkg::out_item_t expected_results[$];
	logic [7:0]          fbuf[$];

	int  err_cnt     = 0;
	int  idle_cycles = 0;
	int  gap_run     = 0;
	int  stall_run   = 0;
	bit  byte_taken  = 1'b0;
	bit  res_taken;

	// decoder model state
	logic [mrfp_pkg::OffsetW-1:0]    fp_offset;
	logic [31:0]                     fp_dest, fp_src, fp_id, fp_port;
	logic [7:0]                      fp_flags, fp_chan;
	mrfp_pkg::phase_t                fp_phase;
	logic [63:0]                     fp_acc;
	logic [mrfp_pkg::VarintCntW-1:0] fp_cnt;
	mrfp_pkg::field_cls_t            fp_cls;
	logic [mrfp_pkg::LenW-1:0]       fp_left;
	logic                            fp_failed;

	mesh_radio_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// no idling once the tail of the run is reached
	function automatic bit calm_tail();
		return frame_bytes_q.size() < CalmBytes;
	endfunction

	// ------------------------------------------------------------------
	// decoder model
	// ------------------------------------------------------------------
	task automatic decoder_clear();
		fp_offset = '0;
		fp_dest   = '0;
		fp_src    = '0;
		fp_id     = '0;
		fp_port   = '0;
		fp_flags  = '0;
		fp_chan   = '0;
		fp_phase  = mrfp_pkg::PH_TAG;
		fp_acc    = '0;
		fp_cnt    = '0;
		fp_cls    = mrfp_pkg::CLS_OTHER;
		fp_left   = '0;
		fp_failed = 1'b0;
	endtask

	task automatic restart_varint(input mrfp_pkg::phase_t p);
		fp_phase = p;
		fp_acc   = '0;
		fp_cnt   = '0;
	endtask

	// advance the model by one frame byte, queue the results it implies
	task automatic predict_frame_byte(input mrfp_pkg::in_item_t it);
		mrfp_pkg::out_item_t r;
		logic [7:0]          b;
		logic [63:0]         v;
		logic [2:0]          w;
		logic                in_hdr, pay, ok;
		int                  o;
		b = it.data_byte;
		o = int'(fp_offset);
		in_hdr = (o < mrfp_pkg::HdrBytes);
		if (in_hdr) begin
			if (o < 4)
				fp_dest[8*(o%4) +: 8] = b;
			else if (o < 8)
				fp_src[8*(o%4) +: 8] = b;
			else if (o < 12)
				fp_id[8*(o%4) +: 8] = b;
			else if (o == 12)
				fp_flags = b;
			else if (o == 13)
				fp_chan = b;
			in_hdr = ((o + 1) < mrfp_pkg::HdrBytes);
		end else begin
			pay = 1'b0;
			if (!fp_failed) begin
				if (fp_phase == mrfp_pkg::PH_BYTES) begin
					// inside a fixed or length-delimited field
					pay = (fp_cls == mrfp_pkg::CLS_PAYLOAD);
					fp_left = fp_left - 1'b1;
					if (fp_left == '0)
						restart_varint(mrfp_pkg::PH_TAG);
				end else begin
					fp_acc = fp_acc | (64'(b[6:0]) << (7 * fp_cnt));
					if (b[7]) begin
						fp_cnt = fp_cnt + 1'b1;
						if (fp_cnt >= mrfp_pkg::VarintMaxBytes)
							fp_failed = 1'b1;
					end else begin
						v = fp_acc;
						if (fp_phase == mrfp_pkg::PH_TAG) begin
							w = v[2:0];
							if ((v >> 3) == 64'd1 && w == mrfp_pkg::WIRE_VARINT) begin
								fp_cls = mrfp_pkg::CLS_PORT;
								restart_varint(mrfp_pkg::PH_VALUE);
							end else if ((v >> 3) == 64'd2 && w == mrfp_pkg::WIRE_LEN) begin
								fp_cls = mrfp_pkg::CLS_PAYLOAD;
								restart_varint(mrfp_pkg::PH_LENGTH);
							end else begin
								fp_cls = mrfp_pkg::CLS_OTHER;
								if (w == mrfp_pkg::WIRE_VARINT)
									restart_varint(mrfp_pkg::PH_VALUE);
								else if (w == mrfp_pkg::WIRE_LEN)
									restart_varint(mrfp_pkg::PH_LENGTH);
								else if (w == mrfp_pkg::WIRE_FIXED64) begin
									fp_phase = mrfp_pkg::PH_BYTES;
									fp_left  = mrfp_pkg::LEN_FIXED64;
								end else if (w == mrfp_pkg::WIRE_FIXED32) begin
									fp_phase = mrfp_pkg::PH_BYTES;
									fp_left  = mrfp_pkg::LEN_FIXED32;
								end else
									fp_failed = 1'b1;
							end
						end else if (fp_phase == mrfp_pkg::PH_VALUE) begin
							if (fp_cls == mrfp_pkg::CLS_PORT)
								fp_port = v[31:0];
							restart_varint(mrfp_pkg::PH_TAG);
						end else begin
							// length of a delimited field
							if (v > mrfp_pkg::MaxFrameBytes)
								fp_failed = 1'b1;
							else if (v == 64'd0)
								restart_varint(mrfp_pkg::PH_TAG);
							else begin
								fp_phase = mrfp_pkg::PH_BYTES;
								fp_left  = v[mrfp_pkg::LenW-1:0];
							end
						end
					end
				end
			end
			r = '0;
			r.item_kind = pay ? mrfp_pkg::KIND_PAYLOAD : mrfp_pkg::KIND_BODY;
			r.body_byte = b;
			expected_results.insert(expected_results.size(), r);
		end
		if (fp_offset < mrfp_pkg::MaxFrameBytes)
			fp_offset = fp_offset + 1'b1;

		// end-of-frame summary
		if (it.last_byte) begin
			r = '0;
			r.item_kind = mrfp_pkg::KIND_SUMMARY;
			if (in_hdr) begin
				r.status = mrfp_pkg::STAT_SHORT;
			end else begin
				ok = !fp_failed && fp_phase == mrfp_pkg::PH_TAG && fp_cnt == '0 &&
				     fp_acc == '0 && fp_port != '0;
				r.destination  = fp_dest;
				r.source_node  = fp_src;
				r.packet_id    = fp_id;
				r.hop_limit    = fp_flags[2:0];
				r.want_ack     = fp_flags[3];
				r.via_mqtt     = fp_flags[4];
				r.hop_start    = fp_flags[7:5];
				r.channel_hash = fp_chan;
				r.port_number  = ok ? fp_port : 32'd0;
				r.status       = ok ? mrfp_pkg::STAT_DECODED : mrfp_pkg::STAT_UNDECODABLE;
			end
			expected_results.insert(expected_results.size(), r);
			decoder_clear();
		end
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic chk_field(input string name, input logic [63:0] e,
	                         input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, actual %0h", name, e, a);
			err_cnt++;
		end
	endtask

	task automatic compare_result(input mrfp_pkg::out_item_t e,
	                              input mrfp_pkg::out_item_t a);
		chk_field("item_kind",    64'(e.item_kind),    64'(a.item_kind));
		chk_field("body_byte",    64'(e.body_byte),    64'(a.body_byte));
		chk_field("destination",  64'(e.destination),  64'(a.destination));
		chk_field("source_node",  64'(e.source_node),  64'(a.source_node));
		chk_field("packet_id",    64'(e.packet_id),    64'(a.packet_id));
		chk_field("hop_limit",    64'(e.hop_limit),    64'(a.hop_limit));
		chk_field("want_ack",     64'(e.want_ack),     64'(a.want_ack));
		chk_field("via_mqtt",     64'(e.via_mqtt),     64'(a.via_mqtt));
		chk_field("hop_start",    64'(e.hop_start),    64'(a.hop_start));
		chk_field("channel_hash", 64'(e.channel_hash), 64'(a.channel_hash));
		chk_field("port_number",  64'(e.port_number),  64'(a.port_number));
		chk_field("status",       64'(e.status),       64'(a.status));
	endtask

	// ------------------------------------------------------------------
	// frame building
	// ------------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b);
		fbuf.insert(fbuf.size(), b);
	endtask

	task automatic add_bytes(input int n);
		repeat (n) put_byte(8'($urandom));
	endtask

	// fill < 0 gives a random header
	task automatic add_hdr(input int fill);
		repeat (mrfp_pkg::HdrBytes) put_byte(fill < 0 ? 8'($urandom) : 8'(fill));
	endtask

	task automatic add_varint(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		while (x > 64'd127) begin
			put_byte({1'b1, x[6:0]});
			x = x >> 7;
		end
		put_byte({1'b0, x[6:0]});
	endtask

	task automatic add_port(input logic [63:0] v);
		add_varint(64'd8);
		add_varint(v);
	endtask

	task automatic add_payload(input int n);
		add_varint(64'h12);
		add_varint(64'(n));
		add_bytes(n);
	endtask

	task automatic add_payload_len_only();
		int n;
		n = $urandom_range(0, 6);
		add_varint(64'(n));
		add_bytes(n);
	endtask

	// a field that the parser skips, of one of the four known wire types
	task automatic add_other();
		int w;
		w = $urandom_range(0, 3);
		w = (w < 3) ? w : 5;
		add_varint(64'($urandom_range(3, 40) * 8 + w));
		case (w)
			0: add_varint({$urandom, $urandom} >> $urandom_range(0, 63));
			1: add_bytes(8);
			2: add_payload_len_only();
			default: add_bytes(4);
		endcase
	endtask

	function automatic logic [63:0] rand_port();
		case ($urandom_range(0, 5))
			0: rand_port = 64'd0;
			1: rand_port = {$urandom, $urandom};
			2: rand_port = 64'($urandom);
			default: rand_port = 64'($urandom_range(1, 300));
		endcase
	endfunction

	// a well-formed body of one to five fields
	task automatic add_random_body();
		bit has_port;
		has_port = 1'b0;
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 3))
				0: begin
					add_port(rand_port());
					has_port = 1'b1;
				end
				1: add_payload($urandom_range(0, 12));
				default: add_other();
			endcase
		end
		if (!has_port && $urandom_range(0, 4) != 0)
			add_port(rand_port());
	endtask

	task automatic emit_frame(input bit hold);
		frame_tx_t t;
		for (int i = 0; i < fbuf.size(); i++) begin
			t.it.data_byte = fbuf[i];
			t.it.last_byte = (i == fbuf.size() - 1);
			t.hold         = hold && (i == 0);
			frame_bytes_q.insert(frame_bytes_q.size(), t);
		end
		fbuf.delete();
	endtask

	// ------------------------------------------------------------------
	// frame-side driver: new transfer at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		frame_tx_t t;
		if (arst_n && (!frame_valid || byte_taken)) begin
			if (gap_run > 0) begin
				gap_run--;
				frame_valid <= 1'b0;
			end else if (frame_bytes_q.size() == 0) begin
				frame_valid <= 1'b0;
			end else if (frame_bytes_q[0].hold && expected_results.size() != 0) begin
				frame_valid <= 1'b0;
			end else if (!calm_tail() && $urandom_range(0, 11) == 0) begin
				gap_run = $urandom_range(1, 18) - 1;
				frame_valid <= 1'b0;
			end else begin
				t = frame_bytes_q.pop_front();
				frame       <= t.it;
				frame_valid <= 1'b1;
			end
		end
	end

	// result-side stall bursts
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
			result_stall <= 1'b1;
		end else if (!calm_tail() && $urandom_range(0, 15) == 0) begin
			stall_run = $urandom_range(1, 18) - 1;
			result_stall <= 1'b1;
		end else
			result_stall <= 1'b0;
	end

	// ------------------------------------------------------------------
	// monitor: predict on each byte transfer, check each result transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		mrfp_pkg::out_item_t e;
		byte_taken = arst_n && frame_valid && !frame_stall;
		res_taken  = arst_n && result_valid && !result_stall;
		if (byte_taken)
			predict_frame_byte(frame);
		if (res_taken) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing predicted: kind %0d byte %02h",
				       result.item_kind, result.body_byte);
				err_cnt++;
			end else begin
				e = expected_results.pop_front();
				compare_result(e, result);
			end
		end
		if (byte_taken || res_taken)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int base;
		int k;
		arst_n = 1'b0;
		decoder_clear();

		// short frames: one byte, and one byte short of a header
		put_byte(8'hff);
		emit_frame(1'b0);
		for (int i = 0; i < 15; i++) put_byte(i[0] ? 8'hff : 8'h00);
		emit_frame(1'b0);
		// header only, empty body
		add_hdr(8'hff);
		emit_frame(1'b0);
		// zero header, zero port
		add_hdr(8'h00);
		add_port(64'd0);
		emit_frame(1'b0);
		// widest port, payload and every skippable wire type
		add_hdr(8'hff);
		add_port(64'hffff_ffff_ffff_ffff);
		add_payload(3);
		add_varint(64'(3 * 8 + mrfp_pkg::WIRE_FIXED64));
		add_bytes(8);
		add_varint(64'(4 * 8 + mrfp_pkg::WIRE_FIXED32));
		add_bytes(4);
		add_varint(64'(5 * 8 + mrfp_pkg::WIRE_LEN));
		add_varint(64'd2);
		add_bytes(2);
		add_varint(64'(6 * 8 + mrfp_pkg::WIRE_VARINT));
		add_varint(64'd300);
		emit_frame(1'b1);
		// overlong varint
		add_hdr(-1);
		add_port(64'd1);
		add_varint(64'd8);
		repeat (10) put_byte(8'h80);
		add_bytes(3);
		emit_frame(1'b0);
		// payload cut off by the end of the frame
		add_hdr(-1);
		add_port(64'd2);
		add_varint(64'h12);
		add_varint(64'd5);
		add_bytes(2);
		emit_frame(1'b0);
		// length above the frame limit
		add_hdr(-1);
		add_port(64'd3);
		add_varint(64'h12);
		add_varint(64'd256);
		add_bytes(2);
		emit_frame(1'b0);
		// unknown wire types
		add_hdr(-1);
		add_port(64'd4);
		add_varint(64'(7 * 8 + 3));
		add_bytes(2);
		emit_frame(1'b0);
		add_hdr(-1);
		add_varint(64'(9 * 8 + 7));
		emit_frame(1'b0);
		// repeated payload and port, empty payload
		add_hdr(-1);
		add_port(64'd9);
		add_payload(2);
		add_payload(0);
		add_port(64'd10);
		add_payload(4);
		emit_frame(1'b0);
		// field numbers with high bits set are not port or payload
		add_hdr(-1);
		add_varint(((64'd1 << 32) + 64'd1) << 3);
		add_varint(64'd77);
		add_varint((((64'd1 << 40) + 64'd2) << 3) + 64'(mrfp_pkg::WIRE_LEN));
		add_varint(64'd1);
		add_bytes(1);
		add_port(64'd5);
		emit_frame(1'b0);
		// field number zero
		add_hdr(-1);
		add_varint(64'd0);
		add_varint(64'd12);
		add_port(64'd6);
		emit_frame(1'b0);
		// frame ends inside a tag
		add_hdr(-1);
		add_port(64'd8);
		put_byte(8'h80);
		emit_frame(1'b0);
		// frame longer than the offset counter
		add_hdr(-1);
		add_port(64'd11);
		add_payload(250);
		add_payload(20);
		emit_frame(1'b0);

		// random frames: mostly well formed, some short, noisy or broken
		base = frame_bytes_q.size();
		while (frame_bytes_q.size() < base + RandBytes) begin
			case ($urandom_range(0, 9))
				6: add_bytes($urandom_range(1, mrfp_pkg::HdrBytes));
				7: begin
					add_hdr(-1);
					add_bytes($urandom_range(0, 20));
				end
				8: begin
					add_hdr(-1);
					add_random_body();
					add_random_body();
					if (fbuf.size() > mrfp_pkg::HdrBytes + 1) begin
						k = $urandom_range(mrfp_pkg::HdrBytes + 1, fbuf.size() - 1);
						while (fbuf.size() > k) void'(fbuf.pop_back());
					end
				end
				9: begin
					add_hdr(-1);
					if ($urandom_range(0, 1)) add_port(rand_port());
					case ($urandom_range(0, 2))
						0: begin
							k = $urandom_range(0, 3);
							k = (k < 2) ? k + 3 : k + 4;
							add_varint(64'($urandom_range(1, 30) * 8 + k));
						end
						1: repeat ($urandom_range(10, 12))
							put_byte(8'h80 | 8'($urandom));
						default: begin
							add_varint($urandom_range(0, 1) ? 64'h12 : 64'h1a);
							add_varint(64'($urandom_range(256, 100000)));
						end
					endcase
					add_bytes($urandom_range(0, 8));
				end
				default: begin
					add_hdr(-1);
					add_random_body();
				end
			endcase
			emit_frame($urandom_range(0, 9) == 0);
		end

		// reset held, then released at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// run until every byte is taken and every result has come
		while (!(frame_bytes_q.size() == 0 && !frame_valid &&
		         expected_results.size() == 0) && idle_cycles < WdLimit)
			@(negedge clk);

		if (idle_cycles >= WdLimit) begin
			$error("watchdog: no transfer for %0d cycles, %0d results outstanding",
			       idle_cycles, expected_results.size());
			$display("mesh_radio_frame_parser_tb: done, errors");
		end else begin
			// stray results would show up here
			repeat (DrainCycles) @(negedge clk);
			if (err_cnt == 0 && expected_results.size() == 0)
				$display("mesh_radio_frame_parser_tb: done, clean");
			else
				$display("mesh_radio_frame_parser_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
